// ===== design/tsb_pkg.sv =====
// Shared types for the tile and sprite blitter: request codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package tsb_pkg;

    typedef enum logic [2:0] {
        REQ_DRAW_TILE   = 3'd0,
        REQ_CLEAR_TILE  = 3'd1,
        REQ_DRAW_SPRITE = 3'd2,
        REQ_RENDER      = 3'd3,
        REQ_SET_MAP     = 3'd4,
        REQ_LOAD_TILE   = 3'd5,
        REQ_LOAD_SPRITE = 3'd6,
        REQ_LOAD_MASK   = 3'd7
    } tsb_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_MAP_RD,
        ST_MAP_LATCH,
        ST_REDUCE,
        ST_TILE,
        ST_SPRITE,
        ST_RENDER
    } tsb_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       accept;     // latch request fields
        logic       clear;      // reset sweep write at clear address
        logic       reduce;     // one modulo step on column and pattern number
        logic       map_latch;  // capture tile map entry
        logic [2:0] idx;        // pattern byte index before mirroring
        logic       half;       // sprite: 0 upper page, 1 lower page
        logic       col_step;   // advance frame column with wrap
        logic       frame_wr;   // write pipelined frame byte
        logic       map_wr;     // write tile map entry
        logic       tbl_wr;     // write pattern or mask table byte
        logic       emit;       // render byte read issued
        logic       emit_last;
        logic [5:0] emit_col;
    } tsb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic reduced;  // column and pattern number are in range
        logic tile_ok;  // request inputs address a valid tile slot
    } tsb_stat_t;

endpackage

`default_nettype wire

// ===== design/tsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/tsb_dp.sv =====
// Blitter datapath: request registers, column and pattern-number reduction,
// frame/map/pattern memories and the render result pipeline.
// Depends on tsb_pkg and tsb_ram.
`default_nettype none

module tsb_dp #(
    parameter int FRAME_COLUMNS = 80,
    parameter int TILE_COLUMNS  = 10,
    parameter int TILE_COUNT    = 128,
    parameter int SPRITE_COUNT  = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [2:0]                          req_type,
    input  wire logic [6:0]                          pos_x,
    input  wire logic [5:0]                          pos_y,
    input  wire logic [7:0]                          sprite_num,
    input  wire logic                                mirror,
    input  wire logic [10:0]                         load_addr,
    input  wire logic [7:0]                          load_data,
    input  wire tsb_pkg::tsb_cmd_t                   cmd,
    input  wire logic [$clog2(FRAME_COLUMNS*8)-1:0]  clear_addr,
    output tsb_pkg::tsb_stat_t                       stat,
    output logic [7:0]                               pixel_byte,
    output logic [5:0]                               view_column,
    output logic [2:0]                               view_page,
    output logic                                     last,
    output logic                                     strobe
);

    localparam int FRAME_BYTES  = FRAME_COLUMNS * 8;
    localparam int MAP_BYTES    = TILE_COLUMNS * 8;
    localparam int TILE_BYTES   = TILE_COUNT * 8;
    localparam int SPRITE_BYTES = SPRITE_COUNT * 8;
    localparam int FAW = $clog2(FRAME_BYTES);
    localparam int CW  = FAW - 3;
    localparam int MAW = $clog2(MAP_BYTES);
    localparam int TXW = MAW - 3;
    localparam int TAW = $clog2(TILE_BYTES);
    localparam int TNW = TAW - 3;
    localparam int SAW = $clog2(SPRITE_BYTES);
    localparam int SNW = SAW - 3;

    tsb_pkg::tsb_req_t req_reg;
    logic [6:0]  px_reg;
    logic [5:0]  py_reg;
    logic [10:0] ld_addr_reg;
    logic [7:0]  ld_data_reg;
    logic [7:0]  num_reg, num_next;
    logic        flip_reg;
    logic [7:0]  col_reg, col_next;
    logic [FAW-1:0] fa_pipe_reg;
    logic        half_pipe_reg;
    logic        strobe_reg;
    logic [5:0]  view_col_reg;
    logic        last_reg;

    logic        is_sprite;
    logic        is_tile_req;
    logic        col_big;
    logic        num_big;
    logic [8:0]  col_inc;
    logic [2:0]  idx_eff;
    logic [2:0]  page_cur;

    logic [7:0]  map_q, tile_q, spat_q, mask_q, frame_q;
    logic [FAW-1:0] frame_raddr, frame_waddr;
    logic [7:0]  frame_wdata;
    logic        frame_we;
    logic [MAW-1:0] map_addr, map_waddr;
    logic [7:0]  map_wdata;
    logic        map_we;
    logic        tile_we, spat_we, mask_we;
    logic [15:0] mask16, spat16;

    assign is_sprite   = (req_reg == tsb_pkg::REQ_DRAW_SPRITE);
    assign is_tile_req = (tsb_pkg::tsb_req_t'(req_type) == tsb_pkg::REQ_DRAW_TILE)
                      || (tsb_pkg::tsb_req_t'(req_type) == tsb_pkg::REQ_CLEAR_TILE);

    assign stat.tile_ok = ({1'b0, pos_x} < 8'(TILE_COLUMNS)) && (pos_y < 6'd8);

    // Modulo by repeated subtraction, one step per cycle
    assign col_big = ({1'b0, col_reg} >= 9'(FRAME_COLUMNS));
    always_comb
    begin
        if (is_sprite)
        begin
            num_big = ({1'b0, num_reg} >= 9'(SPRITE_COUNT));
        end
        else if (req_reg == tsb_pkg::REQ_RENDER)
        begin
            num_big = 1'b0;
        end
        else
        begin
            num_big = ({1'b0, num_reg} >= 9'(TILE_COUNT));
        end
    end
    assign stat.reduced = !col_big && !num_big;

    assign col_inc = {1'b0, col_reg} + 9'd1;

    always_comb
    begin
        col_next = col_reg;
        num_next = num_reg;
        if (cmd.accept)
        begin
            col_next = is_tile_req ? {pos_x[4:0], 3'b000} : {1'b0, pos_x};
            num_next = sprite_num;
        end
        else if (cmd.map_latch)
        begin
            num_next = {1'b0, map_q[6:0]};
        end
        else if (cmd.reduce)
        begin
            if (col_big)
            begin
                col_next = col_reg - 8'(FRAME_COLUMNS);
            end
            if (num_big)
            begin
                num_next = is_sprite ? num_reg - 8'(SPRITE_COUNT)
                                     : num_reg - 8'(TILE_COUNT);
            end
        end
        else if (cmd.col_step)
        begin
            col_next = (col_inc == 9'(FRAME_COLUMNS)) ? 8'd0 : col_inc[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg     <= tsb_pkg::tsb_req_t'(req_type);
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            ld_addr_reg <= load_addr;
            ld_data_reg <= load_data;
            flip_reg    <= mirror;
        end
        else if (cmd.map_latch)
        begin
            flip_reg <= map_q[7];
        end
        col_reg       <= col_next;
        num_reg       <= num_next;
        fa_pipe_reg   <= frame_raddr;
        half_pipe_reg <= cmd.half;
        view_col_reg  <= cmd.emit_col;
        last_reg      <= cmd.emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
        end
    end

    // Addresses
    assign idx_eff  = flip_reg ? ~cmd.idx : cmd.idx;
    assign page_cur = is_sprite ? (py_reg[5:3] + {2'b00, cmd.half}) : py_reg[2:0];
    assign frame_raddr = {col_reg[CW-1:0], page_cur};
    assign map_addr    = {px_reg[TXW-1:0], py_reg[2:0]};

    // Frame write: sweep after reset, else the byte read in the cycle before
    assign mask16 = {8'h00, mask_q} << py_reg[2:0];
    assign spat16 = {8'h00, spat_q} << py_reg[2:0];

    always_comb
    begin
        if (cmd.clear)
        begin
            frame_wdata = 8'h00;
        end
        else
        begin
            case (req_reg)
                tsb_pkg::REQ_DRAW_SPRITE:
                begin
                    if (half_pipe_reg)
                    begin
                        frame_wdata = (frame_q & ~mask16[15:8]) | spat16[15:8];
                    end
                    else
                    begin
                        frame_wdata = (frame_q & ~mask16[7:0]) | spat16[7:0];
                    end
                end
                tsb_pkg::REQ_CLEAR_TILE: frame_wdata = 8'h00;
                default:                 frame_wdata = tile_q;
            endcase
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            frame_we    = 1'b1;
            frame_waddr = clear_addr;
        end
        else
        begin
            // drop the lower-page write of a sprite whose top is in page 7
            frame_we    = cmd.frame_wr
                       && !(is_sprite && half_pipe_reg && (py_reg[5:3] == 3'd7));
            frame_waddr = fa_pipe_reg;
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            map_we    = (clear_addr < FAW'(MAP_BYTES));
            map_waddr = clear_addr[MAW-1:0];
            map_wdata = 8'h00;
        end
        else
        begin
            map_we    = cmd.map_wr;
            map_waddr = map_addr;
            map_wdata = (req_reg == tsb_pkg::REQ_SET_MAP) ? ld_data_reg : 8'h00;
        end
    end

    assign tile_we = cmd.tbl_wr && (req_reg == tsb_pkg::REQ_LOAD_TILE)
                  && ({1'b0, ld_addr_reg} < 12'(TILE_BYTES));
    assign spat_we = cmd.tbl_wr && (req_reg == tsb_pkg::REQ_LOAD_SPRITE)
                  && ({1'b0, ld_addr_reg} < 12'(SPRITE_BYTES));
    assign mask_we = cmd.tbl_wr && (req_reg == tsb_pkg::REQ_LOAD_MASK)
                  && ({1'b0, ld_addr_reg} < 12'(SPRITE_BYTES));

    tsb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_raddr),
        .rdata (frame_q)
    );

    tsb_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_addr),
        .rdata (map_q)
    );

    tsb_ram #(.WIDTH(8), .DEPTH(TILE_BYTES)) u_tile (
        .clk   (clk),
        .we    (tile_we),
        .waddr (ld_addr_reg[TAW-1:0]),
        .wdata (ld_data_reg),
        .raddr ({num_reg[TNW-1:0], idx_eff}),
        .rdata (tile_q)
    );

    tsb_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_spat (
        .clk   (clk),
        .we    (spat_we),
        .waddr (ld_addr_reg[SAW-1:0]),
        .wdata (ld_data_reg),
        .raddr ({num_reg[SNW-1:0], idx_eff}),
        .rdata (spat_q)
    );

    tsb_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_mask (
        .clk   (clk),
        .we    (mask_we),
        .waddr (ld_addr_reg[SAW-1:0]),
        .wdata (ld_data_reg),
        .raddr ({num_reg[SNW-1:0], idx_eff}),
        .rdata (mask_q)
    );

    assign pixel_byte  = frame_q;
    assign view_column = view_col_reg;
    assign view_page   = py_reg[2:0];
    assign last        = last_reg;
    assign strobe      = strobe_reg;

endmodule

`default_nettype wire

// ===== design/tsb_ctrl.sv =====
// Blitter controller: reset sweep, request decode and step sequencing for
// tile, sprite, render and load transactions.
// Depends on tsb_pkg.
`default_nettype none

module tsb_ctrl #(
    parameter int FRAME_COLUMNS = 80,
    parameter int VIEW_COLUMNS  = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [2:0]                          req_type,
    input  wire tsb_pkg::tsb_stat_t                  stat,
    output tsb_pkg::tsb_cmd_t                        cmd,
    output logic [$clog2(FRAME_COLUMNS*8)-1:0]       clear_addr,
    output logic                                     busy
);

    localparam int CNT_W = $clog2(FRAME_COLUMNS * 8);

    tsb_pkg::tsb_state_t state_reg, state_next;
    tsb_pkg::tsb_req_t   op_reg, op_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                tile_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsb_pkg::ST_CLEAR;
            op_reg    <= tsb_pkg::REQ_DRAW_TILE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign tile_op = (op_reg == tsb_pkg::REQ_DRAW_TILE)
                  || (op_reg == tsb_pkg::REQ_CLEAR_TILE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        busy       = 1'b1;

        unique case (state_reg)
            tsb_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (cnt_reg == CNT_W'(FRAME_COLUMNS * 8 - 1))
                begin
                    cnt_next   = '0;
                    state_next = tsb_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tsb_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    op_next    = tsb_pkg::tsb_req_t'(req_type);
                    cnt_next   = '0;
                    unique case (tsb_pkg::tsb_req_t'(req_type))
                        tsb_pkg::REQ_DRAW_TILE, tsb_pkg::REQ_CLEAR_TILE:
                            state_next = stat.tile_ok ? tsb_pkg::ST_MAP_RD : tsb_pkg::ST_IDLE;
                        tsb_pkg::REQ_SET_MAP:
                            state_next = stat.tile_ok ? tsb_pkg::ST_LOAD : tsb_pkg::ST_IDLE;
                        tsb_pkg::REQ_DRAW_SPRITE, tsb_pkg::REQ_RENDER:
                            state_next = tsb_pkg::ST_REDUCE;
                        default:
                            state_next = tsb_pkg::ST_LOAD;
                    endcase
                end
            end

            tsb_pkg::ST_LOAD:
            begin
                if (op_reg == tsb_pkg::REQ_SET_MAP)
                begin
                    cmd.map_wr = 1'b1;
                end
                else
                begin
                    cmd.tbl_wr = 1'b1;
                end
                state_next = tsb_pkg::ST_IDLE;
            end

            tsb_pkg::ST_MAP_RD:
            begin
                state_next = tsb_pkg::ST_MAP_LATCH;
            end

            tsb_pkg::ST_MAP_LATCH:
            begin
                cmd.map_latch = 1'b1;
                state_next    = tsb_pkg::ST_REDUCE;
            end

            tsb_pkg::ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (stat.reduced)
                begin
                    cnt_next = '0;
                    if (tile_op)
                    begin
                        state_next = tsb_pkg::ST_TILE;
                    end
                    else if (op_reg == tsb_pkg::REQ_DRAW_SPRITE)
                    begin
                        state_next = tsb_pkg::ST_SPRITE;
                    end
                    else
                    begin
                        state_next = tsb_pkg::ST_RENDER;
                    end
                end
            end

            tsb_pkg::ST_TILE:
            begin
                // read pattern byte, write it to the frame in the next cycle
                cmd.idx      = cnt_reg[2:0];
                cmd.col_step = (cnt_reg < CNT_W'(8));
                cmd.frame_wr = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(8))
                begin
                    cmd.map_wr = (op_reg == tsb_pkg::REQ_CLEAR_TILE);
                    state_next = tsb_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tsb_pkg::ST_SPRITE:
            begin
                // two frame reads per column: upper page, then lower page
                cmd.idx      = cnt_reg[3:1];
                cmd.half     = cnt_reg[0];
                cmd.col_step = (cnt_reg < CNT_W'(16)) && cnt_reg[0];
                cmd.frame_wr = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(16))
                begin
                    state_next = tsb_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            tsb_pkg::ST_RENDER:
            begin
                cmd.col_step  = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_col  = cnt_reg[5:0];
                cmd.emit_last = (cnt_reg == CNT_W'(VIEW_COLUMNS - 1));
                if (cmd.emit_last)
                begin
                    state_next = tsb_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = tsb_pkg::ST_IDLE;
            end
        endcase
    end

    assign clear_addr = cnt_reg;

endmodule

`default_nettype wire

// ===== design/tile_sprite_blitter_1bpp.sv =====
// Top level of the 1bpp tile and sprite blitter: controller plus datapath.
// Depends on tsb_pkg, tsb_ctrl, tsb_dp (and tsb_ram through tsb_dp).
//
// Usage: a transaction is accepted on a rising edge with start high and busy
// low; the request fields are sampled then. Only a render page transaction
// returns results: VIEW_COLUMNS bytes, one per cycle, each shown for one cycle
// with strobe high, view_column counting from 0 and last on the final byte.
// The receiver cannot stall; results are never held back.
// Steps of a transaction after the accept edge:
//   load byte / set map entry: one write; out-of-range tile request: none.
//   draw / clear tile: map read, map latch, R, then one frame write per column.
//   draw sprite: R, then sixteen frame read-modify-writes on the single frame
//     read port, two per column.
//   render page: R, then VIEW_COLUMNS bytes on the ports, one byte per cycle.
// R is the column / pattern-number reduction, one compare-subtract per cycle.
// After reset busy stays high while the frame memory and tile map are swept
// to zero.
`default_nettype none

module tile_sprite_blitter_1bpp #(
    parameter int FRAME_COLUMNS = 80,
    parameter int VIEW_COLUMNS  = 64,
    parameter int TILE_COLUMNS  = 10,
    parameter int TILE_COUNT    = 128,
    parameter int SPRITE_COUNT  = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  req_type,
    input  wire logic [6:0]  pos_x,
    input  wire logic [5:0]  pos_y,
    input  wire logic [7:0]  sprite_num,
    input  wire logic        mirror,
    input  wire logic [10:0] load_addr,
    input  wire logic [7:0]  load_data,
    output logic             strobe,
    output logic [7:0]       pixel_byte,
    output logic [5:0]       view_column,
    output logic [2:0]       view_page,
    output logic             last
);

    tsb_pkg::tsb_cmd_t  cmd;
    tsb_pkg::tsb_stat_t stat;
    logic [$clog2(FRAME_COLUMNS*8)-1:0] clear_addr;

    tsb_ctrl #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .VIEW_COLUMNS  (VIEW_COLUMNS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .stat       (stat),
        .cmd        (cmd),
        .clear_addr (clear_addr),
        .busy       (busy)
    );

    tsb_dp #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .TILE_COLUMNS  (TILE_COLUMNS),
        .TILE_COUNT    (TILE_COUNT),
        .SPRITE_COUNT  (SPRITE_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .sprite_num  (sprite_num),
        .mirror      (mirror),
        .load_addr   (load_addr),
        .load_data   (load_data),
        .cmd         (cmd),
        .clear_addr  (clear_addr),
        .stat        (stat),
        .pixel_byte  (pixel_byte),
        .view_column (view_column),
        .view_page   (view_page),
        .last        (last),
        .strobe      (strobe)
    );

endmodule

`default_nettype wire

// ===== test/tb_tile_sprite_blitter_1bpp.sv =====
// Testbench for tile_sprite_blitter_1bpp: directed table then random transactions,
// each render byte checked against a typed byte or the in-bench frame/map/table model.
// Depends on tsb_pkg and the design files under design/.
module tb_tile_sprite_blitter_1bpp;
    timeunit 1ns;
    timeprecision 1ps;

    import tsb_pkg::*;

    localparam int FRAME_COLUMNS = 80;
    localparam int VIEW_COLUMNS  = 64;
    localparam int TILE_COLUMNS  = 10;
    localparam int TILE_COUNT    = 128;
    localparam int SPRITE_COUNT  = 256;
    localparam int FRAME_BYTES   = FRAME_COLUMNS * 8;
    localparam int MAP_BYTES     = TILE_COLUMNS * 8;
    localparam int TILE_BYTES    = TILE_COUNT * 8;
    localparam int SPRITE_BYTES  = SPRITE_COUNT * 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 70;

    typedef struct packed {
        tsb_req_t    req;
        logic [6:0]  x;
        logic [5:0]  y;
        logic [7:0]  num;
        logic        mir;
        logic [10:0] addr;
        logic [7:0]  data;
    } blit_txn_t;

    typedef struct packed {
        logic [7:0] pix;
        logic [5:0] col;
        logic [2:0] page;
        logic       last;
    } view_byte_t;

    // lit_pix >= 0 gives the render byte typed in the table; -1 leaves it to the model
    typedef struct packed {
        blit_txn_t txn;
        int        lit_pix;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [6:0]  pos_x;
    logic [5:0]  pos_y;
    logic [7:0]  sprite_num;
    logic        mirror;
    logic [10:0] load_addr;
    logic [7:0]  load_data;
    logic        strobe;
    logic [7:0]  pixel_byte;
    logic [5:0]  view_column;
    logic [2:0]  view_page;
    logic        last;

    logic [7:0] frame_mem [FRAME_BYTES];
    logic [7:0] map_mem   [MAP_BYTES];
    logic [7:0] tile_mem  [TILE_BYTES];
    logic [7:0] spr_mem   [SPRITE_BYTES];
    logic [7:0] mask_mem  [SPRITE_BYTES];
    bit         tile_set  [TILE_BYTES];
    bit         spr_set   [SPRITE_BYTES];
    bit         mask_set  [SPRITE_BYTES];

    view_byte_t view_bytes_due [$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         idle_pct = 15;

    tile_sprite_blitter_1bpp #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .VIEW_COLUMNS  (VIEW_COLUMNS),
        .TILE_COLUMNS  (TILE_COLUMNS),
        .TILE_COUNT    (TILE_COUNT),
        .SPRITE_COUNT  (SPRITE_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .sprite_num  (sprite_num),
        .mirror      (mirror),
        .load_addr   (load_addr),
        .load_data   (load_data),
        .strobe      (strobe),
        .pixel_byte  (pixel_byte),
        .view_column (view_column),
        .view_page   (view_page),
        .last        (last)
    );

    always #6 clk = ~clk;

    function automatic int frame_index(int col, int page);
        return (col % FRAME_COLUMNS) * 8 + (page & 7);
    endfunction

    function automatic plan_row_t plan_row(tsb_req_t req, int x, int y, int num, int mir,
                                           int addr, int data, int lit_pix = -1);
        plan_row_t r;
        r.txn.req  = req;
        r.txn.x    = x[6:0];
        r.txn.y    = y[5:0];
        r.txn.num  = num[7:0];
        r.txn.mir  = mir[0];
        r.txn.addr = addr[10:0];
        r.txn.data = data[7:0];
        r.lit_pix  = lit_pix;
        return r;
    endfunction

    // Update the model with one accepted transaction and queue any render bytes.
    function automatic void apply_blit(blit_txn_t t, int lit_pix);
        int         tx = int'(t.x);
        int         ty = int'(t.y);
        int         slot = tx * 8 + ty;
        bit         tile_ok = (tx < TILE_COLUMNS) && (ty < 8);
        logic [7:0] entry;
        int         base;
        int         page;
        int         disp;
        int         src;
        int         a;
        logic [15:0] m;
        logic [15:0] s;
        view_byte_t vb;

        case (t.req)
            REQ_DRAW_TILE, REQ_CLEAR_TILE:
            begin
                if (tile_ok)
                begin
                    entry = map_mem[slot];
                    base = (int'(entry[6:0]) % TILE_COUNT) * 8;
                    if (t.req == REQ_CLEAR_TILE)
                        map_mem[slot] = 8'h00;
                    for (int i = 0; i < 8; i++)
                    begin
                        a = frame_index(tx * 8 + i, ty);
                        if (t.req == REQ_CLEAR_TILE)
                            frame_mem[a] = 8'h00;
                        else
                            frame_mem[a] = tile_mem[base + (entry[7] ? 7 - i : i)];
                    end
                end
            end
            REQ_DRAW_SPRITE:
            begin
                page = ty >> 3;
                disp = ty & 7;
                base = (int'(t.num) % SPRITE_COUNT) * 8;
                for (int i = 0; i < 8; i++)
                begin
                    src = base + (t.mir ? 7 - i : i);
                    m = {8'h00, mask_mem[src]} << disp;
                    s = {8'h00, spr_mem[src]} << disp;
                    a = frame_index(tx + i, page);
                    frame_mem[a] = (frame_mem[a] & ~m[7:0]) | s[7:0];
                    // page 7 has no page below: clip the spill
                    if (page < 7)
                    begin
                        a = frame_index(tx + i, page + 1);
                        frame_mem[a] = (frame_mem[a] & ~m[15:8]) | s[15:8];
                    end
                end
            end
            REQ_RENDER:
            begin
                for (int col = 0; col < VIEW_COLUMNS; col++)
                begin
                    vb.pix  = (lit_pix >= 0) ? lit_pix[7:0]
                                             : frame_mem[frame_index(tx + col, ty)];
                    vb.col  = col[5:0];
                    vb.page = t.y[2:0];
                    vb.last = (col == VIEW_COLUMNS - 1);
                    view_bytes_due.push_back(vb);
                end
            end
            REQ_SET_MAP:
            begin
                if (tile_ok)
                    map_mem[slot] = t.data;
            end
            REQ_LOAD_TILE:
            begin
                if (int'(t.addr) < TILE_BYTES)
                begin
                    tile_mem[t.addr] = t.data;
                    tile_set[t.addr] = 1'b1;
                end
            end
            REQ_LOAD_SPRITE:
            begin
                spr_mem[t.addr] = t.data;
                spr_set[t.addr] = 1'b1;
            end
            REQ_LOAD_MASK:
            begin
                mask_mem[t.addr] = t.data;
                mask_set[t.addr] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with start held.
    task automatic send_txn(blit_txn_t t, int lit_pix);
        // idle the sender cycle by cycle at the current idle rate
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        req_type   <= t.req;
        pos_x      <= t.x;
        pos_y      <= t.y;
        sprite_num <= t.num;
        mirror     <= t.mir;
        load_addr  <= t.addr;
        load_data  <= t.data;
        start      <= 1'b1;
        do @(posedge clk); while (busy);
        apply_blit(t, lit_pix);
        @(negedge clk);
    endtask

    // Send t, first loading any never-written pattern or mask byte that a draw would read.
    task automatic post_txn(blit_txn_t t, int lit_pix = -1);
        blit_txn_t fill;
        int        base;
        fill = t;
        if (t.req == REQ_DRAW_TILE && int'(t.x) < TILE_COLUMNS && int'(t.y) < 8)
        begin
            base = (int'(map_mem[int'(t.x) * 8 + int'(t.y)][6:0]) % TILE_COUNT) * 8;
            fill.req = REQ_LOAD_TILE;
            for (int i = 0; i < 8; i++)
            begin
                if (!tile_set[base + i])
                begin
                    fill.addr = 11'(base + i);
                    fill.data = 8'($urandom_range(0, 255));
                    send_txn(fill, -1);
                end
            end
        end
        if (t.req == REQ_DRAW_SPRITE)
        begin
            base = (int'(t.num) % SPRITE_COUNT) * 8;
            for (int i = 0; i < 8; i++)
            begin
                fill.addr = 11'(base + i);
                if (!spr_set[base + i])
                begin
                    fill.req  = REQ_LOAD_SPRITE;
                    fill.data = 8'($urandom_range(0, 255));
                    send_txn(fill, -1);
                end
                if (!mask_set[base + i])
                begin
                    fill.req  = REQ_LOAD_MASK;
                    fill.data = 8'($urandom_range(0, 255));
                    send_txn(fill, -1);
                end
            end
        end
        send_txn(t, lit_pix);
    endtask

    always @(posedge clk)
    begin
        view_byte_t want;
        if (rst_n && strobe)
        begin
            if (view_bytes_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected render byte pix=%02h col=%0d page=%0d last=%0b",
                         $time, pixel_byte, view_column, view_page, last);
            end
            else
            begin
                want = view_bytes_due.pop_front();
                if (pixel_byte !== want.pix || view_column !== want.col ||
                    view_page !== want.page || last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: mismatch expected pix=%02h col=%0d page=%0d last=%0b",
                             $time, want.pix, want.col, want.page, want.last);
                    $display("%0t:            actual pix=%02h col=%0d page=%0d last=%0b",
                             $time, pixel_byte, view_column, view_page, last);
                end
            end
        end
    end

    // Count cycles with no transaction accepted and no render byte out; fail past STALL_LIMIT
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        plan_row_t plan [$];
        blit_txn_t t;
        int        pick;

        rst_n      = 1'b0;
        start      = 1'b0;
        req_type   = REQ_DRAW_TILE;
        pos_x      = '0;
        pos_y      = '0;
        sprite_num = '0;
        mirror     = 1'b0;
        load_addr  = '0;
        load_data  = '0;
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
        foreach (map_mem[i]) map_mem[i] = 8'h00;

        //                    req              x    y   num mir addr  data  byte
        plan.push_back(plan_row(REQ_RENDER,      0,   0,   0, 0,    0,    0, 8'h00));
        plan.push_back(plan_row(REQ_RENDER,     79,  63, 255, 1, 2047,  255, 8'h00));
        plan.push_back(plan_row(REQ_RENDER,    127,   8,   0, 0,    0,    0, 8'h00));
        plan.push_back(plan_row(REQ_LOAD_TILE,   0,   0,   0, 0, 1023, 8'hFF));
        plan.push_back(plan_row(REQ_LOAD_TILE,   0,   0,   0, 0, 2047, 8'h55));
        plan.push_back(plan_row(REQ_LOAD_SPRITE, 0,   0,   0, 0, 2047, 8'h81));
        plan.push_back(plan_row(REQ_LOAD_MASK,   0,   0,   0, 0,    0, 8'hFF));
        plan.push_back(plan_row(REQ_SET_MAP,     9,   7,   0, 0,    0, 8'hFF));
        plan.push_back(plan_row(REQ_SET_MAP,    10,   0,   0, 0,    0, 8'h01));
        plan.push_back(plan_row(REQ_SET_MAP,     0,   8,   0, 0,    0, 8'h01));
        plan.push_back(plan_row(REQ_DRAW_TILE,   9,   7,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_DRAW_TILE,   0,   0,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_DRAW_TILE, 127,  63,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_RENDER,     72,   7,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_CLEAR_TILE,  9,   7,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_CLEAR_TILE, 10,   0,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_DRAW_SPRITE,79,  63, 255, 1,    0,    0));
        plan.push_back(plan_row(REQ_DRAW_SPRITE,127,  7,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_DRAW_SPRITE, 0,   0,   0, 1,    0,    0));
        plan.push_back(plan_row(REQ_DRAW_SPRITE,40,  56, 255, 0,    0,    0));
        plan.push_back(plan_row(REQ_DRAW_TILE,   9,   7,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_RENDER,     40,   0,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_RENDER,     16,  15,   0, 0,    0,    0));
        plan.push_back(plan_row(REQ_LOAD_TILE,   0,   0,   0, 0,    0, 8'h00));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            post_txn(plan[i].txn, plan[i].lit_pix);

        for (int phase = 0; phase < 3; phase++)
        begin
            // hold off until every render byte is in
            start <= 1'b0;
            do @(negedge clk); while (view_bytes_due.size() != 0);
            idle_pct = (phase == 0) ? 15 : (phase == 1) ? 47 : 0;

            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                t.x    = 7'($urandom_range(0, 127));
                t.y    = 6'($urandom_range(0, 63));
                t.num  = 8'($urandom_range(0, 255));
                t.mir  = 1'($urandom_range(0, 1));
                t.addr = 11'($urandom_range(0, 2047));
                t.data = 8'($urandom_range(0, 255));
                pick   = $urandom_range(0, 99);
                if (pick < 14)
                    t.req = REQ_DRAW_TILE;
                else if (pick < 22)
                    t.req = REQ_CLEAR_TILE;
                else if (pick < 45)
                    t.req = REQ_DRAW_SPRITE;
                else if (pick < 60)
                    t.req = REQ_RENDER;
                else if (pick < 72)
                    t.req = REQ_SET_MAP;
                else
                    t.req = tsb_req_t'($urandom_range(REQ_LOAD_TILE, REQ_LOAD_MASK));

                // keep most tile ops on the map; draw from a few reused tiles and sprites
                if ((t.req == REQ_DRAW_TILE || t.req == REQ_CLEAR_TILE || t.req == REQ_SET_MAP)
                    && $urandom_range(0, 7) != 0)
                begin
                    t.x = 7'($urandom_range(0, TILE_COLUMNS - 1));
                    t.y = 6'($urandom_range(0, 7));
                end
                if (t.req == REQ_SET_MAP)
                begin
                    pick   = $urandom_range(0, 3);
                    t.data = {t.data[7], 7'((pick < 2) ? pick : 124 + pick)};
                end
                if (t.req == REQ_DRAW_SPRITE)
                begin
                    pick  = $urandom_range(0, 3);
                    t.num = 8'((pick < 2) ? pick : 252 + pick);
                end
                post_txn(t);
            end
        end

        start <= 1'b0;
        do @(negedge clk); while (view_bytes_due.size() != 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && view_bytes_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
design/tsb_pkg.sv
design/tsb_ram.sv
design/tsb_dp.sv
design/tsb_ctrl.sv
design/tile_sprite_blitter_1bpp.sv
test/tb_tile_sprite_blitter_1bpp.sv
